// ===== rtl/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// sps_pkg
// Shared constants and types of the substring position search unit: item
// operation codes, the default string capacity and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package sps_pkg;

    // default capacity of each string in bytes
    localparam int MAX_LEN_DEF = 255;

    // item operation codes
    localparam logic [1:0] OP_APPEND_HAY    = 2'd0;
    localparam logic [1:0] OP_APPEND_NEEDLE = 2'd1;
    localparam logic [1:0] OP_SEARCH        = 2'd2;
    localparam logic [1:0] OP_CLEAR         = 2'd3;

    // commands from controller to datapath
    typedef struct packed {
        logic append_hay;
        logic append_ndl;
        logic clear;
        logic init_search;
        logic next_k;
        logic next_pos;
        logic set_result;
        logic res_found;
        logic res_illegal;
    } sps_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic start_zero;
        logic early_zero;
        logic byte_eq;
        logic last_k;
        logic last_pos;
    } sps_sts_t;

endpackage

// ===== rtl/sps_in_if.sv =====
// ----------------------------------------------------------------------------
// sps_in_if
// Request channel: valid/ready handshake carrying operation, data byte and
// search start position.
// ----------------------------------------------------------------------------
interface sps_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic [7:0] start_pos;

    modport source (output valid, output operation, output data_byte, output start_pos,
                    input ready);
    modport sink   (input valid, input operation, input data_byte, input start_pos,
                    output ready);
endinterface

// ===== rtl/sps_out_if.sv =====
// ----------------------------------------------------------------------------
// sps_out_if
// Result channel: valid/ready handshake carrying match position and status.
// ----------------------------------------------------------------------------
interface sps_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] match_pos;
    logic       status;

    modport source (output valid, output match_pos, output status, input ready);
    modport sink   (input valid, input match_pos, input status, output ready);
endinterface

// ===== rtl/substring_position_search_unit.sv =====
// ----------------------------------------------------------------------------
// substring_position_search_unit
// Keeps a haystack and a needle string loaded byte by byte and reports the
// first 1-based position at or after a start where the needle matches.
//
//   channel   dir   handshake      payload
//   request   in    valid/ready    operation, data_byte, start_pos
//   result    out   valid/ready    match_pos, status
//
// Append and clear items are applied when taken. A search decodes the item,
// then runs the naive position-by-position scan, a read and a compare state
// per byte compare, and loads the result in the done state; cases decided
// without a scan go straight from the decode to the done state. The compare
// loop reads one byte from each string store per pass, with registered read data.
// Reset clears both lengths; stored bytes are not cleared. Requests are taken
// only between searches; a search waits to load its result while the
// previous result is still held on the result channel.
// ----------------------------------------------------------------------------
module substring_position_search_unit #(
    parameter int MAX_LEN = sps_pkg::MAX_LEN_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    sps_in_if.sink    request,
    sps_out_if.source result
);

    sps_pkg::sps_cmd_t cmd;
    sps_pkg::sps_sts_t sts;

    // sequencer
    sps_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .operation (request.operation),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // stores, counters and result register
    sps_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .data_byte (request.data_byte),
        .start_pos (request.start_pos),
        .match_pos (result.match_pos),
        .status    (result.status)
    );

endmodule

// ===== rtl/sps_datapath.sv =====
// ----------------------------------------------------------------------------
// sps_datapath
// String stores, lengths, search position and byte counters, registered
// memory reads and the result register.
// ----------------------------------------------------------------------------
module sps_datapath #(
    parameter int MAX_LEN = sps_pkg::MAX_LEN_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  sps_pkg::sps_cmd_t cmd,
    output sps_pkg::sps_sts_t sts,
    input  logic [7:0]       data_byte,
    input  logic [7:0]       start_pos,
    output logic [7:0]       match_pos,
    output logic             status
);

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW     = ((LEN_W > 8) ? LEN_W : 8) + 1;

    logic [7:0]       hay_mem [MAX_LEN];
    logic [7:0]       ndl_mem [MAX_LEN];

    logic [LEN_W-1:0] hay_len_reg, hay_len_next;
    logic [LEN_W-1:0] ndl_len_reg, ndl_len_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0] k_reg, k_next;
    logic [LEN_W-1:0] last_reg, last_next;
    logic [7:0]       hay_rd_reg;
    logic [7:0]       ndl_rd_reg;
    logic [7:0]       match_pos_reg;
    logic             status_reg;
    logic [LEN_W-1:0] hay_addr;
    logic [CW-1:0]    fit_lhs;
    logic [CW-1:0]    fit_rhs;

    // byte stores, written at the current length
    always_ff @(posedge clk)
    begin
        if (cmd.append_hay && (hay_len_reg < LEN_W'(MAX_LEN)))
        begin
            hay_mem[hay_len_reg[ADDR_W-1:0]] <= data_byte;
        end
        if (cmd.append_ndl && (ndl_len_reg < LEN_W'(MAX_LEN)))
        begin
            ndl_mem[ndl_len_reg[ADDR_W-1:0]] <= data_byte;
        end
    end

    // registered reads at the current compare point
    assign hay_addr = pos_reg - LEN_W'(1) + k_reg;

    always_ff @(posedge clk)
    begin
        hay_rd_reg <= hay_mem[hay_addr[ADDR_W-1:0]];
        ndl_rd_reg <= ndl_mem[k_reg[ADDR_W-1:0]];
    end

    // needle fit test: hay_len + 1 < start + ndl_len means no room
    assign fit_lhs = CW'(hay_len_reg) + CW'(1);
    assign fit_rhs = CW'(start_pos) + CW'(ndl_len_reg);

    always_comb
    begin
        sts.start_zero = (start_pos == 8'd0);
        sts.early_zero = (hay_len_reg == '0) || (ndl_len_reg == '0) || (fit_lhs < fit_rhs);
        sts.byte_eq    = (hay_rd_reg == ndl_rd_reg);
        sts.last_k     = (k_reg == ndl_len_reg - LEN_W'(1));
        sts.last_pos   = (pos_reg == last_reg);
    end

    // lengths and search counters
    always_comb
    begin
        hay_len_next = hay_len_reg;
        ndl_len_next = ndl_len_reg;
        pos_next     = pos_reg;
        k_next       = k_reg;
        last_next    = last_reg;
        if (cmd.clear)
        begin
            hay_len_next = '0;
            ndl_len_next = '0;
        end
        if (cmd.append_hay && (hay_len_reg < LEN_W'(MAX_LEN)))
        begin
            hay_len_next = hay_len_reg + LEN_W'(1);
        end
        if (cmd.append_ndl && (ndl_len_reg < LEN_W'(MAX_LEN)))
        begin
            ndl_len_next = ndl_len_reg + LEN_W'(1);
        end
        if (cmd.init_search)
        begin
            pos_next  = LEN_W'(start_pos);
            k_next    = '0;
            last_next = hay_len_reg - ndl_len_reg + LEN_W'(1);
        end
        if (cmd.next_k)
        begin
            k_next = k_reg + LEN_W'(1);
        end
        if (cmd.next_pos)
        begin
            pos_next = pos_reg + LEN_W'(1);
            k_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hay_len_reg <= '0;
            ndl_len_reg <= '0;
        end
        else
        begin
            hay_len_reg <= hay_len_next;
            ndl_len_reg <= ndl_len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        k_reg    <= k_next;
        last_reg <= last_next;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.set_result)
        begin
            match_pos_reg <= cmd.res_found ? 8'(pos_reg) : 8'd0;
            status_reg    <= cmd.res_illegal;
        end
    end

    assign match_pos = match_pos_reg;
    assign status    = status_reg;

endmodule

// ===== rtl/sps_controller.sv =====
// ----------------------------------------------------------------------------
// sps_controller
// Sequencer for the search: decodes items, steps the compare loop over
// needle bytes and haystack positions, and owns the result valid flag.
// ----------------------------------------------------------------------------
module sps_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        operation,
    output logic              out_valid,
    input  logic              out_ready,
    output sps_pkg::sps_cmd_t cmd,
    input  sps_pkg::sps_sts_t sts
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       found_reg, found_next;
    logic       illegal_reg, illegal_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // next state and datapath commands
    always_comb
    begin
        state_next   = state_reg;
        found_next   = found_reg;
        illegal_next = illegal_reg;
        cmd          = '0;
        cmd.res_found   = found_reg;
        cmd.res_illegal = illegal_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation)
                        sps_pkg::OP_APPEND_HAY:    cmd.append_hay = 1'b1;
                        sps_pkg::OP_APPEND_NEEDLE: cmd.append_ndl = 1'b1;
                        sps_pkg::OP_CLEAR:         cmd.clear      = 1'b1;
                        sps_pkg::OP_SEARCH:
                        begin
                            priority if (sts.start_zero)
                            begin
                                found_next   = 1'b0;
                                illegal_next = 1'b1;
                                state_next   = S_DONE;
                            end
                            else if (sts.early_zero)
                            begin
                                found_next   = 1'b0;
                                illegal_next = 1'b0;
                                state_next   = S_DONE;
                            end
                            else
                            begin
                                cmd.init_search = 1'b1;
                                found_next      = 1'b0;
                                illegal_next    = 1'b0;
                                state_next      = S_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                priority if (sts.byte_eq && sts.last_k)
                begin
                    found_next = 1'b1;
                    state_next = S_DONE;
                end
                else if (sts.byte_eq)
                begin
                    cmd.next_k = 1'b1;
                    state_next = S_READ;
                end
                else if (sts.last_pos)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.next_pos = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.set_result = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.set_result)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            found_reg     <= 1'b0;
            illegal_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            found_reg     <= found_next;
            illegal_reg   <= illegal_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_result |-> (!out_valid_reg || out_ready))
        else $error("result overwritten while pending");

    // a loaded result is presented on the next cycle
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_result |=> out_valid_reg)
        else $error("result not presented");

    // every compare follows a memory read cycle
    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> ($past(state_reg) == S_READ))
        else $error("compare without preceding read");

    // the loop advances only one counter at a time
    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.next_k && cmd.next_pos))
        else $error("both search counters stepped");
`endif

endmodule
